// ===== sv/periodic_neighbor_cell_enumerator_assert.svh =====
`ifndef PERIODIC_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH
`define PERIODIC_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PNCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PNCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/pnce_pkg.sv =====
package pnce_pkg;

   localparam int CELL_W       = 18;
   localparam int CFG_W        = 7;
   localparam int CSR_IDX_W    = 2;
   localparam int SHIFT_W      = 2;
   localparam int CELLS_RESET  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam int NEIGHBOR_SLOTS = 27;
   localparam int SLOT_W         = 5;
   localparam int PLANE_OFFSETS  = 9;
   localparam int ROW_OFFSETS    = 3;

   localparam logic [SLOT_W-1:0] CENTER_SLOT   = SLOT_W'(NEIGHBOR_SLOTS - 1);
   localparam logic [SLOT_W-1:0] CENTER_OFFSET = SLOT_W'(NEIGHBOR_SLOTS / 2);

   localparam logic [1:0] DIGIT_LOW  = 2'd0;
   localparam logic [1:0] DIGIT_HIGH = 2'd2;

   localparam logic signed [SHIFT_W-1:0] SHIFT_NONE = 2'sb00;
   localparam logic signed [SHIFT_W-1:0] SHIFT_POS  = 2'sb01;
   localparam logic signed [SHIFT_W-1:0] SHIFT_NEG  = 2'sb11;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic [1:0] dx;
      logic [1:0] dy;
      logic [1:0] dz;
   } offset_type;

   // Width of one queued query: cell, error, six wrap flags and nine bases.
   function automatic int entry_bits(int aw);
      return CELL_W + 7 + 18 * aw;
   endfunction

   // Slots walk the 26 outer offsets in x, y, z order; the last slot is the center.
   function automatic offset_type slot_offset(logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] t;
      logic [SLOT_W-1:0] r;
      offset_type        o;
      if (s == CENTER_SLOT) begin
         t = CENTER_OFFSET;
      end else if (s >= CENTER_OFFSET) begin
         t = s + SLOT_W'(1);
      end else begin
         t = s;
      end
      if (t >= SLOT_W'(2 * PLANE_OFFSETS)) begin
         o.dx = 2'd2;
         r    = t - SLOT_W'(2 * PLANE_OFFSETS);
      end else if (t >= SLOT_W'(PLANE_OFFSETS)) begin
         o.dx = 2'd1;
         r    = t - SLOT_W'(PLANE_OFFSETS);
      end else begin
         o.dx = 2'd0;
         r    = t;
      end
      if (r >= SLOT_W'(2 * ROW_OFFSETS)) begin
         o.dy = 2'd2;
         o.dz = 2'(r - SLOT_W'(2 * ROW_OFFSETS));
      end else if (r >= SLOT_W'(ROW_OFFSETS)) begin
         o.dy = 2'd1;
         o.dz = 2'(r - SLOT_W'(ROW_OFFSETS));
      end else begin
         o.dy = 2'd0;
         o.dz = 2'(r);
      end
      return o;
   endfunction

endpackage

// ===== sv/pnce_front.sv =====
module pnce_front import pnce_pkg::*; #(
   parameter int AW = 7,
   localparam int EW = entry_bits(AW)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CELL_W-1:0] req_center_cell,
   input  logic [AW-1:0]     cells_x,
   input  logic [AW-1:0]     cells_y,
   input  logic [AW-1:0]     cells_z,
   output logic              push,
   input  logic              full,
   output logic [EW-1:0]     push_data
);

   localparam int CW    = 3 * AW;
   localparam int XW    = (CW > CELL_W) ? CW : CELL_W;
   localparam int CNT_W = (AW > 1) ? $clog2(AW) : 1;

   typedef struct packed {
      logic [CELL_W-1:0]    center_idx;
      logic                 err;
      logic [2:0]           lo;
      logic [2:0]           hi;
      logic [2:0][CW-1:0]   xb;
      logic [2:0][2*AW-1:0] yb;
      logic [2:0][AW-1:0]   zb;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_CHECK,
      S_DIVX,
      S_DIVY,
      S_PUSH
   } state_type;

   state_type         state_ff, state_in;
   logic              hold_valid_ff, hold_valid_in;
   logic [CELL_W-1:0] hold_cell_ff, hold_cell_in;
   logic [XW-1:0]     c_ff, c_in;
   logic [2*AW-1:0]   plz_ff, plz_in;
   logic [CW-1:0]     total_ff, total_in;
   logic [XW-1:0]     rem_ff, rem_in;
   logic [XW-1:0]     dvs_ff, dvs_in;
   logic [AW-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [AW-1:0]     cx_ff, cx_in;
   logic [AW-1:0]     cy_ff, cy_in;
   logic [AW-1:0]     cz_ff, cz_in;
   logic [2*AW-1:0]   r1_ff, r1_in;
   logic              err_ff, err_in;

   logic              accept;
   logic              ge;
   logic [XW-1:0]     rem_next;
   logic [AW-1:0]     q_next;
   logic              div_done;
   entry_type         entry;
   logic [CW-1:0]     xc;
   logic [CW-1:0]     plz_c;
   logic [2*AW-1:0]   yc;
   logic [2*AW-1:0]   lz2;

   assign accept    = req_valid & ~hold_valid_ff;
   assign req_stall = hold_valid_ff;

   // One restoring division step per cycle, shared by both divisions.
   assign ge       = rem_ff >= dvs_ff;
   assign rem_next = ge ? rem_ff - dvs_ff : rem_ff;
   assign q_next   = (q_ff << 1) | AW'(ge);
   assign div_done = cnt_ff == CNT_W'(AW - 1);

   always_comb begin
      state_in      = state_ff;
      hold_valid_in = hold_valid_ff;
      hold_cell_in  = hold_cell_ff;
      c_in          = c_ff;
      plz_in        = plz_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cz_in         = cz_ff;
      r1_in         = r1_ff;
      err_in        = err_ff;
      push          = 1'b0;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cell_in  = req_center_cell;
      end
      case (state_ff)
         S_IDLE: begin
            if (hold_valid_ff) begin
               hold_valid_in = 1'b0;
               c_in          = XW'(hold_cell_ff);
               plz_in        = (2 * AW)'(cells_y) * (2 * AW)'(cells_z);
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            total_in = CW'(cells_x) * CW'(plz_ff);
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (c_ff >= XW'(total_ff)) begin
               err_in   = 1'b1;
               state_in = S_PUSH;
            end else begin
               err_in   = 1'b0;
               rem_in   = c_ff;
               dvs_in   = XW'(plz_ff) << (AW - 1);
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIVX;
            end
         end
         S_DIVX: begin
            rem_in = rem_next;
            if (div_done) begin
               cx_in    = q_next;
               r1_in    = (2 * AW)'(rem_next);
               dvs_in   = XW'(cells_z) << (AW - 1);
               q_in     = '0;
               cnt_in   = '0;
               state_in = S_DIVY;
            end else begin
               dvs_in = dvs_ff >> 1;
               q_in   = q_next;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIVY: begin
            rem_in = rem_next;
            if (div_done) begin
               cy_in    = q_next;
               cz_in    = AW'(rem_next);
               state_in = S_PUSH;
            end else begin
               dvs_in = dvs_ff >> 1;
               q_in   = q_next;
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_PUSH: begin
            if (!full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Neighbor bases per axis: index 0 is the lower neighbor, 1 the center, 2 the upper.
   always_comb begin
      plz_c = CW'(plz_ff);
      xc    = CW'(c_ff) - CW'(r1_ff);
      lz2   = (2 * AW)'(cells_z);
      yc    = r1_ff - (2 * AW)'(cz_ff);

      entry.center_idx = CELL_W'(c_ff);
      entry.err        = err_ff;
      entry.lo[0]      = cx_ff == '0;
      entry.lo[1]      = cy_ff == '0;
      entry.lo[2]      = cz_ff == '0;
      entry.hi[0]      = cx_ff == cells_x - AW'(1);
      entry.hi[1]      = cy_ff == cells_y - AW'(1);
      entry.hi[2]      = cz_ff == cells_z - AW'(1);

      entry.xb[0] = entry.lo[0] ? total_ff - plz_c : xc - plz_c;
      entry.xb[1] = xc;
      entry.xb[2] = entry.hi[0] ? '0 : xc + plz_c;

      entry.yb[0] = entry.lo[1] ? plz_ff - lz2 : yc - lz2;
      entry.yb[1] = yc;
      entry.yb[2] = entry.hi[1] ? '0 : yc + lz2;

      entry.zb[0] = entry.lo[2] ? cells_z - AW'(1) : cz_ff - AW'(1);
      entry.zb[1] = cz_ff;
      entry.zb[2] = entry.hi[2] ? '0 : cz_ff + AW'(1);
   end

   assign push_data = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_cell_ff <= hold_cell_in;
      c_ff         <= c_in;
      plz_ff       <= plz_in;
      total_ff     <= total_in;
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      q_ff         <= q_in;
      cnt_ff       <= cnt_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      r1_ff        <= r1_in;
      err_ff       <= err_in;
   end

endmodule

// ===== sv/pnce_queue.sv =====
`include "periodic_neighbor_cell_enumerator_assert.svh"

module pnce_queue import pnce_pkg::*; #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         valid,
   output logic [W-1:0] head_data
);

   logic [W-1:0]      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign valid     = count_ff != '0;
   assign head_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `PNCE_ASSERT_NOW(a_no_push_when_full, push, !full, "push into a full queue")
   `PNCE_ASSERT_NOW(a_no_pop_when_empty, pop, valid, "pop from an empty queue")
   `PNCE_ASSERT_NEXT(a_push_makes_valid, push && !pop, valid, "pushed entry not visible")

endmodule

// ===== sv/pnce_back.sv =====
`include "periodic_neighbor_cell_enumerator_assert.svh"

module pnce_back import pnce_pkg::*; #(
   parameter int AW = 7,
   localparam int EW = entry_bits(AW)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   output logic                      q_pop,
   input  logic [EW-1:0]             q_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CELL_W-1:0]         rsp_neighbor_cell,
   output logic signed [SHIFT_W-1:0] rsp_shift_x,
   output logic signed [SHIFT_W-1:0] rsp_shift_y,
   output logic signed [SHIFT_W-1:0] rsp_shift_z,
   output logic                      rsp_on_boundary,
   output logic                      rsp_error,
   output logic                      rsp_last
);

   localparam int CW = 3 * AW;
   localparam int XW = (CW > CELL_W) ? CW : CELL_W;

   typedef struct packed {
      logic [CELL_W-1:0]    center_idx;
      logic                 err;
      logic [2:0]           lo;
      logic [2:0]           hi;
      logic [2:0][CW-1:0]   xb;
      logic [2:0][2*AW-1:0] yb;
      logic [2:0][AW-1:0]   zb;
   } entry_type;

   function automatic logic signed [SHIFT_W-1:0] axis_shift(logic [1:0] d, logic lo,
                                                            logic hi);
      logic signed [SHIFT_W-1:0] s;
      s = SHIFT_NONE;
      if (d == DIGIT_LOW && lo) begin
         s = SHIFT_NEG;
      end else if (d == DIGIT_HIGH && hi) begin
         s = SHIFT_POS;
      end
      return s;
   endfunction

   entry_type                 head;
   offset_type                ofs;
   logic [CW-1:0]             idx;
   logic                      center;
   logic                      fin;
   logic                      emit;
   logic                      adv;
   logic                      step;
   logic                      load;
   logic                      wrapped;

   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]         rsp_cell_ff, rsp_cell_in;
   logic signed [SHIFT_W-1:0] rsp_shift_x_ff, rsp_shift_x_in;
   logic signed [SHIFT_W-1:0] rsp_shift_y_ff, rsp_shift_y_in;
   logic signed [SHIFT_W-1:0] rsp_shift_z_ff, rsp_shift_z_in;
   logic                      rsp_bnd_ff, rsp_bnd_in;
   logic                      rsp_err_ff, rsp_err_in;
   logic                      rsp_last_ff, rsp_last_in;

   assign head   = q_data;
   assign ofs    = slot_offset(slot_ff);
   assign idx    = head.xb[ofs.dx] + CW'(head.yb[ofs.dy]) + CW'(head.zb[ofs.dz]);
   assign center = slot_ff == CENTER_SLOT;
   assign fin    = head.err | center;
   assign emit   = fin | (XW'(idx) != XW'(head.center_idx));
   assign adv    = ~rsp_valid_ff | ~rsp_stall;
   assign step   = q_valid & adv;
   assign load   = step & emit;
   assign q_pop  = step & fin;

   always_comb begin
      slot_in        = slot_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_cell_in    = rsp_cell_ff;
      rsp_shift_x_in = rsp_shift_x_ff;
      rsp_shift_y_in = rsp_shift_y_ff;
      rsp_shift_z_in = rsp_shift_z_ff;
      rsp_bnd_in     = rsp_bnd_ff;
      rsp_err_in     = rsp_err_ff;
      rsp_last_in    = rsp_last_ff;
      if (step) begin
         slot_in = fin ? '0 : slot_ff + SLOT_W'(1);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_err_in   = head.err;
         rsp_last_in  = fin;
         rsp_bnd_in   = ~head.err & (|{head.lo, head.hi});
         if (fin) begin
            rsp_cell_in    = head.err ? '0 : head.center_idx;
            rsp_shift_x_in = SHIFT_NONE;
            rsp_shift_y_in = SHIFT_NONE;
            rsp_shift_z_in = SHIFT_NONE;
         end else begin
            rsp_cell_in    = CELL_W'(idx);
            rsp_shift_x_in = axis_shift(ofs.dx, head.lo[0], head.hi[0]);
            rsp_shift_y_in = axis_shift(ofs.dy, head.lo[1], head.hi[1]);
            rsp_shift_z_in = axis_shift(ofs.dz, head.lo[2], head.hi[2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_cell_ff    <= rsp_cell_in;
      rsp_shift_x_ff <= rsp_shift_x_in;
      rsp_shift_y_ff <= rsp_shift_y_in;
      rsp_shift_z_ff <= rsp_shift_z_in;
      rsp_bnd_ff     <= rsp_bnd_in;
      rsp_err_ff     <= rsp_err_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_neighbor_cell = rsp_cell_ff;
   assign rsp_shift_x       = rsp_shift_x_ff;
   assign rsp_shift_y       = rsp_shift_y_ff;
   assign rsp_shift_z       = rsp_shift_z_ff;
   assign rsp_on_boundary   = rsp_bnd_ff;
   assign rsp_error         = rsp_err_ff;
   assign rsp_last          = rsp_last_ff;

   assign wrapped = (rsp_shift_x_ff != SHIFT_NONE) || (rsp_shift_y_ff != SHIFT_NONE) ||
                    (rsp_shift_z_ff != SHIFT_NONE);

   `PNCE_ASSERT_NOW(a_slot_idle, !q_valid, slot_ff == '0, "slot counter moved without a query")
   `PNCE_ASSERT_NOW(a_shift_bnd, rsp_valid_ff && wrapped, rsp_bnd_ff, "wrap without boundary flag")
   `PNCE_ASSERT_NOW(a_err_last, rsp_valid_ff && rsp_err_ff, rsp_last_ff, "error result not last")

endmodule

// ===== sv/periodic_neighbor_cell_enumerator.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_center_cell
// rsp       out        rsp_valid/rsp_stall  rsp_neighbor_cell, rsp_shift_x/y/z,
//                                           rsp_on_boundary, rsp_error, rsp_last
// csr       in         csr_write            csr_index, csr_wdata
//
// On the result side the back end steps through each of the 26 outer offsets (skipped
// neighbors included) and then the final center result. A query out of range yields
// only an error result, and the front end skips both divisions for it. A valid query
// passes through two restoring divisions of one bit per cycle in the front end.
// Reset sets all three axes to 3 cells and empties the queue; there is no clearing pass.
// A stall on rsp freezes the back end. req_stall is high while the front end holds an
// accepted request not yet taken in, so also once the two queue entries and front end fill.
module periodic_neighbor_cell_enumerator import pnce_pkg::*; #(
   parameter int MAX_CELLS_PER_AXIS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [CELL_W-1:0]         req_center_cell,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [CELL_W-1:0]         rsp_neighbor_cell,
   output logic signed [SHIFT_W-1:0] rsp_shift_x,
   output logic signed [SHIFT_W-1:0] rsp_shift_y,
   output logic signed [SHIFT_W-1:0] rsp_shift_z,
   output logic                      rsp_on_boundary,
   output logic                      rsp_error,
   output logic                      rsp_last,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   localparam int AW   = $clog2(MAX_CELLS_PER_AXIS + 1);
   localparam int CMPW = (AW > CFG_W) ? AW : CFG_W;
   localparam int EW   = entry_bits(AW);
   localparam logic [AW-1:0] CELLS_INIT =
      AW'((CELLS_RESET > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : CELLS_RESET);

   // A written zero counts as one cell; values above the maximum saturate.
   function automatic logic [AW-1:0] clamp_cells(logic [CFG_W-1:0] v);
      logic [CMPW-1:0] w;
      w = CMPW'(v);
      if (w == '0) begin
         w = CMPW'(1);
      end
      if (w > CMPW'(MAX_CELLS_PER_AXIS)) begin
         w = CMPW'(MAX_CELLS_PER_AXIS);
      end
      return AW'(w);
   endfunction

   logic [AW-1:0] cells_x_ff, cells_x_in;
   logic [AW-1:0] cells_y_ff, cells_y_in;
   logic [AW-1:0] cells_z_ff, cells_z_in;

   logic          push;
   logic          full;
   logic [EW-1:0] push_data;
   logic          pop;
   logic          q_valid;
   logic [EW-1:0] head_data;

   always_comb begin
      cells_x_in = cells_x_ff;
      cells_y_in = cells_y_ff;
      cells_z_in = cells_z_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CELLS_X: cells_x_in = clamp_cells(csr_wdata);
            CSR_CELLS_Y: cells_y_in = clamp_cells(csr_wdata);
            CSR_CELLS_Z: cells_z_in = clamp_cells(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CELLS_INIT;
         cells_y_ff <= CELLS_INIT;
         cells_z_ff <= CELLS_INIT;
      end else begin
         cells_x_ff <= cells_x_in;
         cells_y_ff <= cells_y_in;
         cells_z_ff <= cells_z_in;
      end
   end

   pnce_front #(
      .AW(AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_center_cell (req_center_cell),
      .cells_x         (cells_x_ff),
      .cells_y         (cells_y_ff),
      .cells_z         (cells_z_ff),
      .push            (push),
      .full            (full),
      .push_data       (push_data)
   );

   pnce_queue #(
      .W(EW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .valid     (q_valid),
      .head_data (head_data)
   );

   pnce_back #(
      .AW(AW)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_pop             (pop),
      .q_data            (head_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_neighbor_cell (rsp_neighbor_cell),
      .rsp_shift_x       (rsp_shift_x),
      .rsp_shift_y       (rsp_shift_y),
      .rsp_shift_z       (rsp_shift_z),
      .rsp_on_boundary   (rsp_on_boundary),
      .rsp_error         (rsp_error),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== bench/periodic_neighbor_cell_checker.sv =====
`timescale 1ns / 1ps

module periodic_neighbor_cell_checker import pnce_pkg::*; #(
   parameter int MAX_CELLS_PER_AXIS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [CELL_W-1:0]         req_center_cell,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [CELL_W-1:0]         rsp_neighbor_cell,
   input  logic signed [SHIFT_W-1:0] rsp_shift_x,
   input  logic signed [SHIFT_W-1:0] rsp_shift_y,
   input  logic signed [SHIFT_W-1:0] rsp_shift_z,
   input  logic                      rsp_on_boundary,
   input  logic                      rsp_error,
   input  logic                      rsp_last,
   input  logic                      csr_write,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata,
   output int                        mismatch_count,
   output int                        neighbors_seen,
   output int                        pending_neighbors
);

   typedef struct packed {
      logic [CELL_W-1:0]         nbr_idx;
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
      logic signed [SHIFT_W-1:0] shift_z;
      logic                      on_boundary;
      logic                      error;
      logic                      last;
   } neighbor_type;

   neighbor_type expected_neighbors[$];
   int           grid_x = CELLS_RESET;
   int           grid_y = CELLS_RESET;
   int           grid_z = CELLS_RESET;

   function automatic int fit_axis(input logic [CFG_W-1:0] value);
      if (value == '0) begin
         return 1;
      end
      if (int'(value) > MAX_CELLS_PER_AXIS) begin
         return MAX_CELLS_PER_AXIS;
      end
      return int'(value);
   endfunction

   function automatic int wrap_coord(input int c, input int d, input int len,
                                     output logic signed [SHIFT_W-1:0] shift);
      int n;
      n     = c + d;
      shift = SHIFT_NONE;
      if (n < 0) begin
         n     = n + len;
         shift = SHIFT_NEG;
      end else if (n >= len) begin
         n     = n - len;
         shift = SHIFT_POS;
      end
      return n;
   endfunction

   function automatic void enumerate_neighbors(input logic [CELL_W-1:0] center);
      int                        c;
      int                        cx, cy, cz;
      int                        nx, ny, nz;
      int                        idx;
      int                        emitted;
      logic                      bnd;
      logic signed [SHIFT_W-1:0] sx, sy, sz;
      neighbor_type              item;
      c    = int'(center);
      item = '0;
      if (c >= grid_x * grid_y * grid_z) begin
         item.error = 1'b1;
         item.last  = 1'b1;
         expected_neighbors.insert(expected_neighbors.size(), item);
         return;
      end
      cx  = c / (grid_y * grid_z);
      cy  = (c / grid_z) % grid_y;
      cz  = c % grid_z;
      bnd = (cx == 0) || (cx == grid_x - 1) || (cy == 0) || (cy == grid_y - 1) ||
            (cz == 0) || (cz == grid_z - 1);
      emitted = 0;
      for (int dx = -1; dx <= 1; dx++) begin
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dz = -1; dz <= 1; dz++) begin
               nx  = wrap_coord(cx, dx, grid_x, sx);
               ny  = wrap_coord(cy, dy, grid_y, sy);
               nz  = wrap_coord(cz, dz, grid_z, sz);
               idx = (nx * grid_y + ny) * grid_z + nz;
               if (idx != c && emitted < NEIGHBOR_SLOTS - 1) begin
                  item.nbr_idx     = CELL_W'(idx);
                  item.shift_x     = sx;
                  item.shift_y     = sy;
                  item.shift_z     = sz;
                  item.on_boundary = bnd;
                  expected_neighbors.insert(expected_neighbors.size(), item);
                  emitted++;
               end
            end
         end
      end
      item             = '0;
      item.nbr_idx     = center;
      item.on_boundary = bnd;
      item.last        = 1'b1;
      expected_neighbors.insert(expected_neighbors.size(), item);
   endfunction

   always @(posedge clock) begin : watch
      neighbor_type got;
      neighbor_type want;
      if (reset) begin
         grid_x = CELLS_RESET;
         grid_y = CELLS_RESET;
         grid_z = CELLS_RESET;
         expected_neighbors.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CELLS_X: grid_x = fit_axis(csr_wdata);
               CSR_CELLS_Y: grid_y = fit_axis(csr_wdata);
               CSR_CELLS_Z: grid_z = fit_axis(csr_wdata);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            enumerate_neighbors(req_center_cell);
         end
         if (rsp_valid && !rsp_stall) begin
            neighbors_seen++;
            got.nbr_idx     = rsp_neighbor_cell;
            got.shift_x     = rsp_shift_x;
            got.shift_y     = rsp_shift_y;
            got.shift_z     = rsp_shift_z;
            got.on_boundary = rsp_on_boundary;
            got.error       = rsp_error;
            got.last        = rsp_last;
            if (expected_neighbors.size() == 0) begin
               mismatch_count++;
               $display("%0t: expected no result", $time);
               $display("%0t:   actual cell %0d shift %0d/%0d/%0d bnd %0b err %0b last %0b",
                        $time, got.nbr_idx, got.shift_x, got.shift_y, got.shift_z,
                        got.on_boundary, got.error, got.last);
            end else begin
               want = expected_neighbors.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display("%0t: expected cell %0d shift %0d/%0d/%0d bnd %0b err %0b last %0b",
                           $time, want.nbr_idx, want.shift_x, want.shift_y, want.shift_z,
                           want.on_boundary, want.error, want.last);
                  $display("%0t:   actual cell %0d shift %0d/%0d/%0d bnd %0b err %0b last %0b",
                           $time, got.nbr_idx, got.shift_x, got.shift_y, got.shift_z,
                           got.on_boundary, got.error, got.last);
               end
            end
         end
      end
      pending_neighbors <= expected_neighbors.size();
   end

endmodule

// ===== bench/tb_periodic_neighbor_cell_enumerator.sv =====
`timescale 1ns / 1ps

module tb_periodic_neighbor_cell_enumerator;
   import pnce_pkg::*;

   localparam int MAX_CELLS_PER_AXIS = 64;
   localparam int LIMIT_CYCLES       = 600000;
   localparam int SETTLE_CYCLES      = 60;
   localparam int RANDOM_PHASES      = 8;
   localparam int QUERIES_PER_PHASE  = 31;
   localparam int CELL_MAX           = 2 ** CELL_W - 1;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CELL_W-1:0]         req_center_cell = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [CELL_W-1:0]         rsp_neighbor_cell;
   logic signed [SHIFT_W-1:0] rsp_shift_x;
   logic signed [SHIFT_W-1:0] rsp_shift_y;
   logic signed [SHIFT_W-1:0] rsp_shift_z;
   logic                      rsp_on_boundary;
   logic                      rsp_error;
   logic                      rsp_last;
   logic                      csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CFG_W-1:0]          csr_wdata = '0;

   int mismatch_count;
   int neighbors_seen;
   int pending_neighbors;
   int idle_pct       = 0;
   int stall_pct      = 0;
   int dim_x          = CELLS_RESET;
   int dim_y          = CELLS_RESET;
   int dim_z          = CELLS_RESET;
   int queries_sent   = 0;
   int settings_used  = 1;
   int cycle_count    = 0;

   periodic_neighbor_cell_enumerator #(
      .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
   ) u_dut (.*);

   periodic_neighbor_cell_checker #(
      .MAX_CELLS_PER_AXIS(MAX_CELLS_PER_AXIS)
   ) u_neighbor_check (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic send_query(input int cell_index);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_center_cell <= CELL_W'(cell_index);
      queries_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_neighbors != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_grid(input int x, input int y, input int z);
      csr_write <= 1'b1;
      csr_index <= CSR_CELLS_X;
      csr_wdata <= CFG_W'(x);
      @(posedge clock);
      csr_index <= CSR_CELLS_Y;
      csr_wdata <= CFG_W'(y);
      @(posedge clock);
      csr_index <= CSR_CELLS_Z;
      csr_wdata <= CFG_W'(z);
      @(posedge clock);
      csr_write <= 1'b0;
      dim_x = x;
      dim_y = y;
      dim_z = z;
      settings_used++;
   endtask

   function automatic int pick_coord(input int len);
      case ($urandom_range(3))
         0:       return 0;
         1:       return len - 1;
         default: return $urandom_range(len - 1);
      endcase
   endfunction

   function automatic int pick_cell();
      int total;
      int roll;
      total = dim_x * dim_y * dim_z;
      roll  = $urandom_range(99);
      if (roll < 12) begin
         return int'($urandom_range(CELL_MAX));
      end
      if (roll < 18 && total + 3 <= CELL_MAX) begin
         return total + int'($urandom_range(3));
      end
      return (pick_coord(dim_x) * dim_y + pick_coord(dim_y)) * dim_z + pick_coord(dim_z);
   endfunction

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL periodic_neighbor_cell_enumerator");
      $finish;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_query(0);
      send_query(13);
      send_query(26);
      send_query(27);
      send_query(CELL_MAX);
      drain_results();

      set_grid(1, 1, 1);
      send_query(0);
      send_query(1);
      drain_results();

      set_grid(2, 2, 2);
      send_query(0);
      send_query(7);
      send_query(3);
      drain_results();

      set_grid(2, 1, 3);
      send_query(0);
      send_query(5);
      send_query(6);
      drain_results();

      set_grid(64, 64, 64);
      send_query(0);
      send_query(CELL_MAX);
      send_query(133152);
      drain_results();

      // Zero is read as one cell and oversized counts saturate at the axis limit.
      set_grid(0, 127, 65);
      send_query(0);
      send_query(4095);
      send_query(4096);
      send_query(2080);
      drain_results();

      set_grid(1, 3, 64);
      send_query(100);
      send_query(191);
      send_query(192);
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 75;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 75;
            end
            default: begin
               idle_pct  = 30;
               stall_pct = 30;
            end
         endcase
         set_grid(($urandom_range(2) == 0) ? $urandom_range(3, 1)
                                           : $urandom_range(MAX_CELLS_PER_AXIS, 1),
                  ($urandom_range(2) == 0) ? $urandom_range(3, 1)
                                           : $urandom_range(MAX_CELLS_PER_AXIS, 1),
                  ($urandom_range(2) == 0) ? $urandom_range(3, 1)
                                           : $urandom_range(MAX_CELLS_PER_AXIS, 1));
         repeat (QUERIES_PER_PHASE) send_query(pick_cell());
         drain_results();
      end

      $display("Sent %0d center cells under %0d grid settings and checked %0d neighbor results.",
               queries_sent, settings_used, neighbors_seen);
      $display("Phases ran without gaps, with sparse requests, with heavy result stalls and mixed.");
      if (mismatch_count == 0) begin
         $display("PASS periodic_neighbor_cell_enumerator");
      end else begin
         $display("FAIL periodic_neighbor_cell_enumerator");
      end
      $finish;
   end

endmodule
